// ----- rtl/assert_macros.svh -----
// Assertion helpers; expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/asmd_pkg.sv -----
package asmd_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] word_t;
  typedef logic        [DataWidth-1:0] uword_t;

  localparam uword_t WordOne = {{(DataWidth-1){1'b0}}, 1'b1};

  typedef struct packed {
    word_t operand_a;
    word_t operand_b;
  } in_item_t;

  typedef struct packed {
    word_t total;
    word_t difference;
    word_t product_low;
    word_t quotient_out;
    word_t remainder_out;
    logic  divide_by_zero;
  } out_item_t;

  // Divider working set plus the fields that ride along with it.
  typedef struct packed {
    uword_t rem;
    uword_t quo;
    uword_t divisor;
    logic   neg_q;
    logic   neg_r;
    logic   dz;
    word_t  total;
    word_t  difference;
    word_t  product_low;
  } div_work_t;

  function automatic uword_t neg_word(uword_t v);
    return (~v) + WordOne;
  endfunction

  function automatic uword_t abs_word(word_t v);
    return v[DataWidth-1] ? neg_word(uword_t'(v)) : uword_t'(v);
  endfunction

endpackage

// ----- rtl/asmd_div_stage.sv -----
module asmd_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  asmd_pkg::div_work_t work_i,
  output logic                valid_o,
  output asmd_pkg::div_work_t work_o
);
  import asmd_pkg::*;

  logic [DataWidth:0] shifted;
  logic [DataWidth:0] trial;
  logic               fits;
  div_work_t          work_d;
  div_work_t          work_q;
  logic               valid_q;

  // One restoring step: shift in the next dividend bit, try the subtract.
  always_comb begin
    shifted     = {work_i.rem, work_i.quo[DataWidth-1]};
    trial       = shifted - {1'b0, work_i.divisor};
    fits        = ~trial[DataWidth];
    work_d      = work_i;
    work_d.rem  = fits ? trial[DataWidth-1:0] : shifted[DataWidth-1:0];
    work_d.quo  = {work_i.quo[DataWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ----- rtl/signed_add_sub_mul_div_unit.sv -----
// Pipeline: input register, operand prep with sum/difference/product, 32 divide
// stages, output register.
// Throughput: one item per cycle; each stage holds one restoring divide step.
// A stall on the output holds the whole pipeline in place.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
module signed_add_sub_mul_div_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  asmd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output asmd_pkg::out_item_t out_item_o
);
  import asmd_pkg::*;

  `include "assert_macros.svh"

  logic      adv;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      prep_valid_q;
  div_work_t prep_d;
  div_work_t prep_q;
  logic      chain_valid [DataWidth+1];
  div_work_t chain_work  [DataWidth+1];
  out_item_t out_d;
  out_item_t out_q;
  logic      out_valid_q;
  div_work_t last;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  always_comb begin
    prep_d             = '0;
    prep_d.rem         = '0;
    prep_d.quo         = abs_word(in_q.operand_a);
    prep_d.divisor     = abs_word(in_q.operand_b);
    prep_d.neg_q       = in_q.operand_a[DataWidth-1] ^ in_q.operand_b[DataWidth-1];
    prep_d.neg_r       = in_q.operand_a[DataWidth-1];
    prep_d.dz          = (in_q.operand_b == '0);
    prep_d.total       = in_q.operand_a + in_q.operand_b;
    prep_d.difference  = in_q.operand_a - in_q.operand_b;
    prep_d.product_low = in_q.operand_a * in_q.operand_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prep_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      in_valid_q   <= in_valid_i;
      prep_valid_q <= in_valid_q;
      out_valid_q  <= chain_valid[DataWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q   <= in_item_i;
      prep_q <= prep_d;
      out_q  <= out_d;
    end
  end

  assign chain_valid[0] = prep_valid_q;
  assign chain_work[0]  = prep_q;

  for (genvar k = 0; k < DataWidth; k++) begin : g_div
    asmd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_valid[k]),
      .work_i  (chain_work[k]),
      .valid_o (chain_valid[k+1]),
      .work_o  (chain_work[k+1])
    );
  end

  assign last = chain_work[DataWidth];

  // Sign fixup; divide by zero forces the quotient to all ones.
  always_comb begin
    out_d.total          = last.total;
    out_d.difference     = last.difference;
    out_d.product_low    = last.product_low;
    out_d.divide_by_zero = last.dz;
    if (last.dz) begin
      out_d.quotient_out = '1;
    end else if (last.neg_q) begin
      out_d.quotient_out = word_t'(neg_word(last.quo));
    end else begin
      out_d.quotient_out = word_t'(last.quo);
    end
    out_d.remainder_out = last.neg_r ? word_t'(neg_word(last.rem)) : word_t'(last.rem);
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_NEXT(a_in_capture, in_valid_i && !in_stall_o, in_valid_q, "accepted item lost at input register")
  `ASSERT_IMPLY(a_backpressure, out_valid_o && out_stall_i, in_stall_o, "input taken while output stalled")
  `ASSERT_IMPLY(a_dz_quotient, out_valid_o && out_item_o.divide_by_zero, out_item_o.quotient_out == '1, "divide by zero quotient not all ones")

endmodule

// ----- tb/signed_add_sub_mul_div_unit_tb.sv -----
module signed_add_sub_mul_div_unit_tb;
  import asmd_pkg::*;

  localparam int     RandomItems = 1300;
  localparam int     CycleLimit  = 200000;
  localparam int     HoldCycles  = 200;
  localparam int     DrainCycles = 40;
  localparam word_t  MinWord     = word_t'({1'b1, {(DataWidth-1){1'b0}}});
  localparam word_t  MaxWord     = word_t'({1'b0, {(DataWidth-1){1'b1}}});
  localparam word_t  ZeroWord    = '0;
  localparam word_t  AllOnes     = '1;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } arith_row_t;

  logic      clk_i        = 1'b0;
  logic      rst_ni       = 1'b0;
  logic      in_valid     = 1'b0;
  in_item_t  in_item      = '0;
  logic      out_stall    = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  logic      no_idle      = 1'b0;
  logic      hold_request = 1'b0;
  logic      hold_done    = 1'b0;
  int        hold_left    = 0;

  out_item_t  expected_results[$];
  arith_row_t directed_rows[$];
  int         fail_count      = 0;
  int         results_checked = 0;
  int         pairs_sent      = 0;
  int         zero_divisors   = 0;
  int         cycle_count     = 0;

  signed_add_sub_mul_div_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic out_item_t compute_arith(in_item_t it);
    out_item_t r;
    uword_t    mag_a;
    uword_t    mag_b;
    uword_t    mag_q;
    uword_t    mag_r;
    logic      neg_a;
    logic      neg_b;
    neg_a = it.operand_a[DataWidth-1];
    neg_b = it.operand_b[DataWidth-1];
    mag_a = neg_a ? uword_t'(-it.operand_a) : uword_t'(it.operand_a);
    mag_b = neg_b ? uword_t'(-it.operand_b) : uword_t'(it.operand_b);
    r.total       = it.operand_a + it.operand_b;
    r.difference  = it.operand_a - it.operand_b;
    r.product_low = it.operand_a * it.operand_b;
    if (it.operand_b == ZeroWord) begin
      r.quotient_out   = AllOnes;
      r.remainder_out  = it.operand_a;
      r.divide_by_zero = 1'b1;
    end else begin
      mag_q = mag_a / mag_b;
      mag_r = mag_a % mag_b;
      r.quotient_out   = (neg_a ^ neg_b) ? word_t'(-mag_q) : word_t'(mag_q);
      r.remainder_out  = neg_a ? word_t'(-mag_r) : word_t'(mag_r);
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  function automatic word_t rand_operand();
    word_t v;
    v = word_t'($urandom);
    case ($urandom_range(9, 0))
      0:       return MinWord;
      1:       return MaxWord;
      2:       return ZeroWord;
      3:       return AllOnes;
      4:       return word_t'($urandom_range(32, 0)) - 16;
      5, 6:    return v >>> $urandom_range(DataWidth - 1, 1);
      default: return v;
    endcase
  endfunction

  task automatic add_checked(word_t a, word_t b, word_t t, word_t d, word_t p,
                             word_t q, word_t r, logic z);
    arith_row_t row;
    row.stim.operand_a      = a;
    row.stim.operand_b      = b;
    row.typed               = 1'b1;
    row.want.total          = t;
    row.want.difference     = d;
    row.want.product_low    = p;
    row.want.quotient_out   = q;
    row.want.remainder_out  = r;
    row.want.divide_by_zero = z;
    directed_rows.push_back(row);
  endtask

  task automatic add_predicted(word_t a, word_t b);
    arith_row_t row;
    row.stim.operand_a = a;
    row.stim.operand_b = b;
    row.typed          = 1'b0;
    row.want           = '0;
    directed_rows.push_back(row);
  endtask

  task automatic send_pair(in_item_t it, bit typed, out_item_t want, bit allow_gap);
    int gap;
    gap = (allow_gap && $urandom_range(99, 0) < 30) ? $urandom_range(2, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    expected_results.push_back(typed ? want : compute_arith(it));
    pairs_sent++;
    if (it.operand_b == ZeroWord) zero_divisors++;
  endtask

  task automatic check_field(string name, word_t want, word_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99, 0) < 30);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("total", want.total, out_item.total);
        check_field("difference", want.difference, out_item.difference);
        check_field("product_low", want.product_low, out_item.product_low);
        check_field("quotient_out", want.quotient_out, out_item.quotient_out);
        check_field("remainder_out", want.remainder_out, out_item.remainder_out);
        check_field("divide_by_zero", word_t'({{(DataWidth-1){1'b0}}, want.divide_by_zero}),
                    word_t'({{(DataWidth-1){1'b0}}, out_item.divide_by_zero}));
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t none;
    bit        quiet;
    none = '0;

    add_checked(0, 0, 0, 0, 0, AllOnes, 0, 1'b1);
    add_checked(5, 0, 5, 5, 0, AllOnes, 5, 1'b1);
    add_checked(-1, 0, -1, -1, 0, AllOnes, -1, 1'b1);
    add_checked(MaxWord, 0, MaxWord, MaxWord, 0, AllOnes, MaxWord, 1'b1);
    add_checked(MinWord, 0, MinWord, MinWord, 0, AllOnes, MinWord, 1'b1);
    add_checked(MinWord, -1, MaxWord, MinWord + 1, MinWord, MinWord, 0, 1'b0);
    add_checked(MaxWord, MaxWord, -2, 0, 1, 1, 0, 1'b0);
    add_checked(MinWord, MinWord, 0, 0, 0, 1, 0, 1'b0);
    add_checked(MinWord, 1, MinWord + 1, MaxWord, MinWord, MinWord, 0, 1'b0);
    add_checked(7, 2, 9, 5, 14, 3, 1, 1'b0);
    add_checked(-7, 2, -5, -9, -14, -3, -1, 1'b0);
    add_checked(7, -2, 5, 9, -14, -3, 1, 1'b0);
    add_checked(-7, -2, -9, -5, 14, 3, -1, 1'b0);
    add_predicted(MaxWord, -1);
    add_predicted(MinWord, MaxWord);
    add_predicted(MaxWord, MinWord);
    add_predicted(1, MinWord);
    add_predicted(-1, MaxWord);
    add_predicted(0, MinWord);
    add_predicted(MinWord, 2);
    add_predicted(word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA));
    add_predicted(-1, -1);
    add_predicted(MaxWord, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want, 1'b1);

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 200) hold_request <= 1'b1;
      if (n == 800) begin
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      quiet = (n >= 500 && n < 750);
      no_idle <= quiet;
      case ($urandom_range(19, 0))
        0: begin
          it.operand_a = MinWord;
          it.operand_b = AllOnes;
        end
        1: begin
          it.operand_a = rand_operand();
          it.operand_b = ZeroWord;
        end
        default: begin
          it.operand_a = rand_operand();
          it.operand_b = rand_operand();
        end
      endcase
      send_pair(it, 1'b0, none, !quiet && !(n >= 200 && n < 420));
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d operand pairs sent (%0d directed), %0d with a zero divisor",
             pairs_sent, directed_rows.size(), zero_divisors);
    $display("%0d results checked, %0d mismatches, with a long output hold-off",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/asmd_pkg.sv
rtl/asmd_div_stage.sv
rtl/signed_add_sub_mul_div_unit.sv
tb/signed_add_sub_mul_div_unit_tb.sv
